### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms. Defining NO_ASSERTIONS removes them all.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The condition holds at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed: condition does not hold");

// When the antecedent holds, the consequent holds in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication does not hold");

// When the antecedent holds, the consequent holds in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication does not hold");

`else

`define ASSERT_ALWAYS(label, clk, rst, cond)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### src/kopl_pkg.sv
// ----------------------------------------------------------------------------
// kopl_pkg
// Request codes and field widths of the k-th occurrence position lookup.
// ----------------------------------------------------------------------------
package kopl_pkg;

   // Field widths fixed by the beat layout.
   localparam int VALUE_W = 16;
   localparam int OCC_W   = 13;
   localparam int POS_W   = 13;
   localparam int KIND_W  = 2;

   // Request kinds carried on tuser.
   localparam logic [KIND_W-1:0] REQ_APPEND = 2'd0;
   localparam logic [KIND_W-1:0] REQ_QUERY  = 2'd1;
   localparam logic [KIND_W-1:0] REQ_CLEAR  = 2'd2;

endpackage

### src/kth_occurrence_position_lookup_unit.sv
// ----------------------------------------------------------------------------
// kth_occurrence_position_lookup_unit
// Occurrence index: appends values, answers k-th occurrence position queries, clears.
// ----------------------------------------------------------------------------
// Usage:
//  Requests arrive on the req_ stream. tuser carries the kind (append, query,
//  clear); tdata carries the value and, for queries, the wanted occurrence.
//  Only a query produces a response beat on the rsp_ stream, holding the
//  1-based position of the occurrence, or zero when it does not exist.
//  Per-value count, list head and list tail share one memory; the slot links
//  sit in a second memory. Both have a registered read.
//  An append reads the value entry, then writes it back.
//  A query walks the list from its head one hop after another through the
//  link memory port, since each hop needs the previous read, and answers
//  zero straight away when the occurrence does not exist. Unsupported
//  kinds are dropped.
//  After reset, and after every clear, the count memory is swept to zero at
//  one entry per cycle, with req_tready held low.
//  The response sits in an output register; a new request is taken while it
//  waits. If the receiver stalls, a finished query holds until the register
//  is free, and no further request is taken meanwhile.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kth_occurrence_position_lookup_unit #(
   parameter int MAX_ITEMS   = 4096,
   parameter int VALUE_COUNT = 65536
) (
   input  logic        clock,
   input  logic        reset,
   // Request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] value, [28:16] occurrence, [31:29] zero
   input  logic [1:0]  req_tuser,   // [1:0] req_type
   // Response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [12:0] position, [15:13] zero
);

   localparam int SLOT_W  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int CNT_W   = $clog2(MAX_ITEMS + 1);
   localparam int VADDR_W = $clog2(VALUE_COUNT);
   localparam int CMP_W   = (CNT_W > kopl_pkg::OCC_W) ? CNT_W : kopl_pkg::OCC_W;
   localparam bit LIMITED = (VALUE_COUNT < 65536);

   typedef struct packed {
      logic [CNT_W-1:0]  count;
      logic [SLOT_W-1:0] head;
      logic [SLOT_W-1:0] tail;
   } entry_type;

   typedef enum logic [2:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_LOOK,
      ST_WALK,
      ST_DONE
   } state_type;

   // Registers
   state_type                    state_ff, state_in;
   logic [kopl_pkg::KIND_W-1:0]  kind_ff, kind_in;
   logic [kopl_pkg::VALUE_W-1:0] value_ff, value_in;
   logic [kopl_pkg::OCC_W-1:0]   occ_ff, occ_in;
   logic [kopl_pkg::OCC_W-1:0]   rem_ff, rem_in;
   logic [kopl_pkg::POS_W-1:0]   pos_ff, pos_in;
   logic [kopl_pkg::POS_W-1:0]   rsp_data_ff, rsp_data_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]             item_count_ff, item_count_in;
   logic [VADDR_W-1:0]           sweep_ff, sweep_in;

   // Memories and their ports
   entry_type          val_mem [VALUE_COUNT];
   logic [SLOT_W-1:0]  link_mem [MAX_ITEMS];
   entry_type          val_rdata_ff;
   logic [SLOT_W-1:0]  link_rdata_ff;
   logic [VADDR_W-1:0] val_raddr, val_waddr;
   entry_type          val_wdata;
   logic               val_we;
   logic [SLOT_W-1:0]  link_raddr, link_waddr, link_wdata;
   logic               link_we;

   // Decoded conditions
   logic              req_fire;
   logic              in_range;
   logic              full;
   logic              k_zero;
   logic              k_over;
   logic [SLOT_W-1:0] new_slot;

   // Position of a slot, wrapped to the field width.
   function automatic logic [kopl_pkg::POS_W-1:0] slot_pos(input logic [SLOT_W-1:0] s);
      logic [SLOT_W:0] p;
      p = {1'b0, s} + (SLOT_W + 1)'(1);
      return kopl_pkg::POS_W'(p);
   endfunction

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = 16'(rsp_data_ff);

   // Request checks on the latched beat and the entry just read.
   assign in_range = !LIMITED || (32'(value_ff) < 32'(VALUE_COUNT));
   assign full     = (item_count_ff == CNT_W'(MAX_ITEMS));
   assign k_zero   = (occ_ff == '0);
   assign k_over   = (CMP_W'(occ_ff) > CMP_W'(val_rdata_ff.count));
   assign new_slot = SLOT_W'(item_count_ff);

   // Read addresses: the value entry at acceptance, the link chain while walking.
   assign val_raddr  = VADDR_W'(req_tdata[kopl_pkg::VALUE_W-1:0]);
   assign link_raddr = (state_ff == ST_LOOK) ? val_rdata_ff.head : link_rdata_ff;

   // Next-state and memory write logic.
   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      value_in      = value_ff;
      occ_in        = occ_ff;
      rem_in        = rem_ff;
      pos_in        = pos_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      item_count_in = item_count_ff;
      sweep_in      = sweep_ff;
      val_we        = 1'b0;
      val_waddr     = VADDR_W'(value_ff);
      val_wdata     = val_rdata_ff;
      link_we       = 1'b0;
      link_waddr    = val_rdata_ff.tail;
      link_wdata    = new_slot;

      unique case (state_ff)
         ST_SWEEP: begin
            val_we          = 1'b1;
            val_waddr       = sweep_ff;
            val_wdata       = '0;
            sweep_in        = sweep_ff + VADDR_W'(1);
            if (sweep_ff == VADDR_W'(VALUE_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (req_fire) begin
               kind_in  = req_tuser;
               value_in = req_tdata[kopl_pkg::VALUE_W-1:0];
               occ_in   = req_tdata[kopl_pkg::VALUE_W +: kopl_pkg::OCC_W];
               state_in = ST_LOOK;
            end
         end

         ST_LOOK: begin
            unique case (kind_ff)
               kopl_pkg::REQ_APPEND: begin
                  state_in = ST_IDLE;
                  if (in_range && !full) begin
                     // Link the new slot behind the current tail, or start the list.
                     val_we          = 1'b1;
                     val_wdata.count = val_rdata_ff.count + CNT_W'(1);
                     val_wdata.head  = (val_rdata_ff.count == '0) ? new_slot
                                                                  : val_rdata_ff.head;
                     val_wdata.tail  = new_slot;
                     link_we         = (val_rdata_ff.count != '0);
                     item_count_in   = item_count_ff + CNT_W'(1);
                  end
               end
               kopl_pkg::REQ_QUERY: begin
                  priority if (!in_range || k_zero || k_over) begin
                     pos_in   = '0;
                     state_in = ST_DONE;
                  end else if (occ_ff == kopl_pkg::OCC_W'(1)) begin
                     pos_in   = slot_pos(val_rdata_ff.head);
                     state_in = ST_DONE;
                  end else begin
                     // The link read of the head is under way; count the hops left.
                     rem_in   = occ_ff - kopl_pkg::OCC_W'(1);
                     state_in = ST_WALK;
                  end
               end
               kopl_pkg::REQ_CLEAR: begin
                  item_count_in = '0;
                  sweep_in      = '0;
                  state_in      = ST_SWEEP;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end

         ST_WALK: begin
            if (rem_ff == kopl_pkg::OCC_W'(1)) begin
               pos_in   = slot_pos(link_rdata_ff);
               state_in = ST_DONE;
            end else begin
               rem_in = rem_ff - kopl_pkg::OCC_W'(1);
            end
         end

         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = pos_ff;
               state_in     = ST_IDLE;
            end
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SWEEP;
         sweep_ff      <= '0;
         item_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sweep_ff      <= sweep_in;
         item_count_ff <= item_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      kind_ff     <= kind_in;
      value_ff    <= value_in;
      occ_ff      <= occ_in;
      rem_ff      <= rem_in;
      pos_ff      <= pos_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Per-value entry memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (val_we) begin
         val_mem[val_waddr] <= val_wdata;
      end
      val_rdata_ff <= val_mem[val_raddr];
   end

   // Slot link memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_waddr] <= link_wdata;
      end
      link_rdata_ff <= link_mem[link_raddr];
   end

   // Checks on the control logic.
   `ASSERT_ALWAYS(a_count_bound, clock, reset, item_count_ff <= CNT_W'(MAX_ITEMS))
   `ASSERT_IMPLIES(a_walk_hops, clock, reset, state_ff == ST_WALK, rem_ff != '0)
   `ASSERT_NEXT(a_done_emits, clock, reset, state_ff == ST_DONE && (!rsp_valid_ff || rsp_tready), rsp_valid_ff && state_ff == ST_IDLE)
   `ASSERT_NEXT(a_clear_sweeps, clock, reset, state_ff == ST_LOOK && kind_ff == kopl_pkg::REQ_CLEAR, state_ff == ST_SWEEP && item_count_ff == '0 && sweep_ff == '0)

endmodule

### test/tb.sv
// ----------------------------------------------------------------------------
// tb: k-th occurrence position lookup testbench
// Drives append, query, clear and unused-kind beats into the unit and checks every
// response beat against a scoreboard that keeps its own occurrence index.
// It runs a directed opening, random phases under changing back-pressure and
// a fill to full capacity that reaches the dropped append and long walks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

   localparam int VALUE_SPAN = 65536;
   localparam int SLOT_SPAN  = 4096;
   localparam int POOL_SIZE  = 6;
   localparam logic [kopl_pkg::KIND_W-1:0] REQ_UNUSED = 2'd3;

   // Scoreboard: a private occurrence index and the queue of positions owed.
   class kth_position_scoreboard;
      bit [12:0]   value_count [VALUE_SPAN];
      bit [11:0]   first_slot [VALUE_SPAN];
      bit [11:0]   last_slot [VALUE_SPAN];
      bit [11:0]   slot_link [SLOT_SPAN];
      int          used_slots;
      logic [12:0] expected_positions [$];
      int          failures;

      function int count_of(input logic [15:0] value);
         return int'(value_count[value]);
      endfunction

      function int pending();
         return expected_positions.size();
      endfunction

      // Adds one owed position behind the others.
      function void owe_position(input logic [12:0] pos);
         expected_positions = {expected_positions, pos};
      endfunction

      // Updates the index for one accepted request beat.
      function void note_request(input logic [1:0] kind, input logic [15:0] value,
                                 input logic [12:0] occ);
         int slot;
         int step;
         case (kind)
            kopl_pkg::REQ_APPEND: begin
               // A full index drops the append and keeps its state.
               if (used_slots < SLOT_SPAN) begin
                  if (value_count[value] == 0)
                     first_slot[value] = 12'(used_slots);
                  else
                     slot_link[last_slot[value]] = 12'(used_slots);
                  last_slot[value] = 12'(used_slots);
                  value_count[value]++;
                  used_slots++;
               end
            end
            kopl_pkg::REQ_QUERY: begin
               // A zero occurrence, or more than the count, answers zero.
               if (occ == 0 || int'(occ) > int'(value_count[value])) begin
                  owe_position(13'd0);
               end else begin
                  slot = int'(first_slot[value]);
                  for (step = 1; step < int'(occ); step++)
                     slot = int'(slot_link[slot]);
                  owe_position(13'(slot + 1));
               end
            end
            kopl_pkg::REQ_CLEAR: begin
               foreach (value_count[i]) value_count[i] = '0;
               used_slots = 0;
            end
            default: ;
         endcase
      endfunction

      // Compares one response beat with the oldest owed position.
      function void check_position(input logic [12:0] actual);
         logic [12:0] wanted;
         if (expected_positions.size() == 0) begin
            $error("position: expected none, actual %0d", actual);
            failures++;
            return;
         end
         wanted = expected_positions.pop_front();
         if (actual !== wanted) begin
            $error("position: expected %0d, actual %0d", wanted, actual);
            failures++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // [15:0] value, [28:16] occurrence, [31:29] zero
   logic [1:0]  req_tuser;   // [1:0] req_type
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // [12:0] position, [15:13] zero

   kth_position_scoreboard scoreboard;
   int          send_idle_pct;
   int          recv_idle_pct;
   int          clears_left;
   logic [15:0] value_pool [POOL_SIZE];

   kth_occurrence_position_lookup_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Run limit, far beyond the slowest correct run.
   initial begin
      #(40_000_000);
      $display("kth_occurrence_position_lookup_unit test failed");
      $finish;
   end

   // Receiver back-pressure, changed at the falling edge.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Response beats are checked at the rising edge.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         scoreboard.check_position(rsp_tdata[12:0]);
   end

   // Presents one request beat and waits until it is taken.
   task automatic send_request(input logic [1:0] kind, input logic [15:0] value,
                               input logic [12:0] occ);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {3'b000, occ, value};
      do @(posedge clock); while (!req_tready);
      scoreboard.note_request(kind, value, occ);
      @(negedge clock);
   endtask

   // Holds the request side idle until every owed position has arrived.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (scoreboard.pending() != 0) @(negedge clock);
   endtask

   task automatic refresh_pool();
      foreach (value_pool[i]) value_pool[i] = 16'($urandom_range(65535));
   endtask

   function automatic logic [15:0] pick_value();
      if ($urandom_range(99) < 85)
         return value_pool[$urandom_range(POOL_SIZE - 1)];
      return 16'($urandom_range(65535));
   endfunction

   // Mostly occurrences that exist, with zero, one past the count and noise.
   function automatic logic [12:0] pick_occurrence(input int count);
      int roll;
      roll = $urandom_range(99);
      if (count > 0 && roll < 70) return 13'($urandom_range(count, 1));
      if (roll < 80) return '0;
      if (roll < 90) return 13'(count + 1);
      return 13'($urandom_range(8191));
   endfunction

   // Random traffic: appends and queries over a small set of hot values, with rare clears and unused kinds.
   task automatic random_phase(input int items);
      int          done;
      int          roll;
      logic [15:0] value;
      done = 0;
      while (done < items) begin
         roll = $urandom_range(199);
         if (roll < 4) begin
            // Unused kind, ignored by the unit and not counted.
            send_request(REQ_UNUSED, 16'($urandom_range(65535)),
                         13'($urandom_range(8191)));
         end else begin
            if (roll < 5 && clears_left > 0) begin
               send_request(kopl_pkg::REQ_CLEAR, 16'($urandom_range(65535)), '0);
               clears_left--;
               refresh_pool();
            end else if (roll < 95) begin
               send_request(kopl_pkg::REQ_APPEND, pick_value(),
                            13'($urandom_range(8191)));
            end else begin
               value = pick_value();
               send_request(kopl_pkg::REQ_QUERY, value,
                            pick_occurrence(scoreboard.count_of(value)));
            end
            done++;
         end
         if ($urandom_range(249) == 0) wait_drained();
      end
      wait_drained();
   endtask

   // Fills the index to capacity, overflows it and walks long lists.
   task automatic fill_phase();
      logic [15:0] fill_vals [4];
      logic [15:0] value;
      logic [15:0] final_value;
      int          roll;
      foreach (fill_vals[i]) fill_vals[i] = 16'($urandom_range(65535));
      send_request(kopl_pkg::REQ_CLEAR, '0, '0);
      final_value = fill_vals[0];
      for (int n = 0; n < SLOT_SPAN; n++) begin
         roll  = $urandom_range(99);
         value = (roll < 60) ? fill_vals[0] : (roll < 80) ? fill_vals[1] : fill_vals[2];
         send_request(kopl_pkg::REQ_APPEND, value, '0);
         final_value = value;
      end
      // These appends find the index full and are dropped.
      repeat (4) send_request(kopl_pkg::REQ_APPEND, fill_vals[3], '0);
      send_request(kopl_pkg::REQ_QUERY, fill_vals[3], 13'd1);
      send_request(kopl_pkg::REQ_QUERY, final_value,
                   13'(scoreboard.count_of(final_value)));
      for (int i = 0; i < 3; i++) begin
         send_request(kopl_pkg::REQ_QUERY, fill_vals[i],
                      13'(scoreboard.count_of(fill_vals[i])));
         send_request(kopl_pkg::REQ_QUERY, fill_vals[i], 13'd1);
         send_request(kopl_pkg::REQ_QUERY, fill_vals[i],
                      13'(scoreboard.count_of(fill_vals[i]) + 1));
      end
      wait_drained();
      send_request(kopl_pkg::REQ_CLEAR, '0, '0);
      send_request(kopl_pkg::REQ_QUERY, fill_vals[0], 13'd1);
      send_request(kopl_pkg::REQ_APPEND, fill_vals[0], '0);
      send_request(kopl_pkg::REQ_QUERY, fill_vals[0], 13'd1);
   endtask

   // Main sequence.
   initial begin
      scoreboard    = new();
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = kopl_pkg::REQ_APPEND;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      clears_left   = 2;
      refresh_pool();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed opening: empty index, extremes, zero and excess occurrence,
      // the unused kind and a clear.
      send_request(kopl_pkg::REQ_QUERY,  16'd0,      13'd1);
      send_request(kopl_pkg::REQ_APPEND, 16'd0,      13'd0);
      send_request(kopl_pkg::REQ_APPEND, 16'hFFFF,   13'h1FFF);
      send_request(kopl_pkg::REQ_APPEND, 16'd0,      13'd0);
      send_request(kopl_pkg::REQ_QUERY,  16'd0,      13'd1);
      send_request(kopl_pkg::REQ_QUERY,  16'd0,      13'd2);
      send_request(kopl_pkg::REQ_QUERY,  16'd0,      13'd3);
      send_request(kopl_pkg::REQ_QUERY,  16'd0,      13'd0);
      send_request(kopl_pkg::REQ_QUERY,  16'hFFFF,   13'd1);
      send_request(kopl_pkg::REQ_QUERY,  16'hFFFF,   13'h1FFF);
      send_request(kopl_pkg::REQ_QUERY,  16'd0,      13'd4096);
      send_request(kopl_pkg::REQ_QUERY,  16'h5A5A,   13'd1);
      send_request(REQ_UNUSED,           16'd0,      13'd1);
      send_request(kopl_pkg::REQ_QUERY,  16'd0,      13'd2);
      send_request(kopl_pkg::REQ_CLEAR,  16'hFFFF,   13'h1FFF);
      send_request(kopl_pkg::REQ_QUERY,  16'd0,      13'd1);
      send_request(kopl_pkg::REQ_APPEND, 16'hFFFF,   13'd0);
      send_request(kopl_pkg::REQ_APPEND, 16'hFFFF,   13'd0);
      send_request(kopl_pkg::REQ_QUERY,  16'hFFFF,   13'd2);
      send_request(kopl_pkg::REQ_QUERY,  16'hFFFF,   13'd1);
      wait_drained();

      // Random phases under changing idling on both sides.
      send_idle_pct = 24;
      recv_idle_pct = 54;
      random_phase(533);
      send_idle_pct = 54;
      recv_idle_pct = 24;
      random_phase(533);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_phase(534);

      send_idle_pct = 10;
      recv_idle_pct = 10;
      fill_phase();

      // Let the last beats settle, then report.
      wait_drained();
      repeat (100) @(negedge clock);
      if (scoreboard.pending() != 0) begin
         $error("position: %0d expected beats never arrived", scoreboard.pending());
         scoreboard.failures++;
      end
      if (scoreboard.failures == 0) begin
         $display("kth_occurrence_position_lookup_unit test passed");
      end else begin
         $display("kth_occurrence_position_lookup_unit test failed");
      end
      $finish;
   end

endmodule
